// ----- hw/rtl/bbg_pkg.sv -----
// bbg_pkg: shared types and constants for the butterworth bin gain block
// command and status structs between controller and datapath, register indexes
// no dependencies
package bbg_pkg;

    localparam int CNT_W  = 7;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 32;

    localparam logic [IDX_W-1:0] REG_TYPE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_ORDER = 3'd1;
    localparam logic [IDX_W-1:0] REG_WIN   = 3'd2;
    localparam logic [IDX_W-1:0] REG_HCUT  = 3'd3;
    localparam logic [IDX_W-1:0] REG_LCUT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_BW    = 3'd5;

    localparam logic [1:0] TYPE_HP = 2'd0;
    localparam logic [1:0] TYPE_LP = 2'd1;
    localparam logic [1:0] TYPE_BP = 2'd2;
    localparam logic [1:0] TYPE_BR = 2'd3;

    localparam logic [47:0] ACC_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic load;       // capture item, set up mirror modulo
        logic neg_save;   // mirror address from modulo remainder
        logic divq_init;  // start ratio division
        logic div_step;
        logic pow_init;
        logic pow_step;
        logic divs_init;  // start 1/(1+p) or p/(1+p) division
        logic sqrt_init;
        logic sqrt_step;
        logic mul;        // bandwidth term
        logic acc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] pow_last;  // 2n-2
    } t_sts;

endpackage

// ----- hw/rtl/butterworth_bin_gain_top.sv -----
// butterworth bin gain: Butterworth magnitude for one frequency bin per item
//
// input channel: i_in_valid / o_in_stall carry i_bin_index and i_first_bin.
// output channel: o_out_valid / i_out_stall carry o_gain (Q1.16), o_pos_index,
// o_neg_index (mirror address) and o_bandwidth_sum (saturating Q32.16 sum of
// gain times bin width; i_first_bin clears it before the bin is added).
// config: i_cfg_we writes i_cfg_data into register i_cfg_index (0 type, 1 order,
// 2 window, 3 high cut, 4 low cut, 5 bin width); write only while idle.
// one item at a time: from acceptance to the result being loaded, the item passes
// the bit-serial divider run three times (window modulo, ratio, 1/(1+p) or
// p/(1+p)), the 2n-1 step power multiply (n = clamped order) and the 17-step
// square root. the next item is taken the cycle after the result is
// loaded, even while that result waits on a stalled receiver.
// a finished result waits in its phase until the output register is free.
// reset: registers return to lowpass, order 4, window 1024, high cut 1.0,
// low cut 256.0, bin width 1.0 Hz; the bandwidth sum is cleared.
module butterworth_bin_gain_top #(
    parameter int WINDOW_MAX = 65536,
    parameter int ORDER_MAX  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bbg_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [bbg_pkg::DATA_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [14:0]                  i_bin_index,
    input  logic                         i_first_bin,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [16:0]                  o_gain,
    output logic [14:0]                  o_pos_index,
    output logic [15:0]                  o_neg_index,
    output logic [47:0]                  o_bandwidth_sum
);

    bbg_pkg::t_cmd cmd;
    bbg_pkg::t_sts sts;

    bbg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bbg_dp #(
        .WINDOW_MAX (WINDOW_MAX),
        .ORDER_MAX  (ORDER_MAX)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_bin_index     (i_bin_index),
        .i_first_bin     (i_first_bin),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_gain          (o_gain),
        .o_pos_index     (o_pos_index),
        .o_neg_index     (o_neg_index),
        .o_bandwidth_sum (o_bandwidth_sum)
    );

endmodule

// ----- hw/rtl/bbg_ctrl.sv -----
// bbg_ctrl: sequencer for the butterworth bin gain block
// steps the shared divider, power loop and square root; uses bbg_pkg
module bbg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  bbg_pkg::t_sts   i_sts,
    output bbg_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MOD   = 4'd1;
    localparam logic [3:0] S_NEGQ  = 4'd2;
    localparam logic [3:0] S_DIVQ  = 4'd3;
    localparam logic [3:0] S_POWI  = 4'd4;
    localparam logic [3:0] S_POW   = 4'd5;
    localparam logic [3:0] S_DIVSI = 4'd6;
    localparam logic [3:0] S_DIVS  = 4'd7;
    localparam logic [3:0] S_SQI   = 4'd8;
    localparam logic [3:0] S_SQRT  = 4'd9;
    localparam logic [3:0] S_MUL   = 4'd10;
    localparam logic [3:0] S_ACC   = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    localparam logic [bbg_pkg::CNT_W-1:0] MOD_LAST  = 7'd14;
    localparam logic [bbg_pkg::CNT_W-1:0] DIV_LAST  = 7'd30;
    localparam logic [bbg_pkg::CNT_W-1:0] SQRT_LAST = 7'd16;

    logic [3:0]                 r_state, n_state;
    logic [bbg_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                       r_out_valid, n_out_valid;
    logic                       out_free;
    bbg_pkg::t_cmd              cmd;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt + 7'd1;
        n_out_valid = r_out_valid && i_out_stall;
        cmd         = '0;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_MOD;
                end
            end
            S_MOD: begin
                cmd.div_step = 1'b1;
                if (r_cnt == MOD_LAST) begin
                    n_state = S_NEGQ;
                    n_cnt   = '0;
                end
            end
            S_NEGQ: begin
                cmd.neg_save  = 1'b1;
                cmd.divq_init = 1'b1;
                n_state       = S_DIVQ;
                n_cnt         = '0;
            end
            S_DIVQ: begin
                cmd.div_step = 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_POWI;
                    n_cnt   = '0;
                end
            end
            S_POWI: begin
                cmd.pow_init = 1'b1;
                n_state      = S_POW;
                n_cnt        = '0;
            end
            S_POW: begin
                cmd.pow_step = 1'b1;
                if (r_cnt == i_sts.pow_last) begin
                    n_state = S_DIVSI;
                    n_cnt   = '0;
                end
            end
            S_DIVSI: begin
                cmd.divs_init = 1'b1;
                n_state       = S_DIVS;
                n_cnt         = '0;
            end
            S_DIVS: begin
                cmd.div_step = 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_SQI;
                    n_cnt   = '0;
                end
            end
            S_SQI: begin
                cmd.sqrt_init = 1'b1;
                n_state       = S_SQRT;
                n_cnt         = '0;
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (r_cnt == SQRT_LAST) begin
                    n_state = S_MUL;
                    n_cnt   = '0;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_ACC;
                n_cnt   = '0;
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                n_state = S_DONE;
                n_cnt   = '0;
            end
            S_DONE: begin
                n_cnt = '0;
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef ASSERT_OFF
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted but next item not held off");
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result shown without finishing the sequence");
    a_cnt_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != $past(r_state) |-> r_cnt == '0)
        else $error("step counter not cleared on phase change");
`endif

endmodule

// ----- hw/rtl/bbg_dp.sv -----
// bbg_dp: datapath of the butterworth bin gain block
// config registers, shared restoring divider, power multiplier, square root,
// bandwidth accumulator and output register; uses bbg_pkg
module bbg_dp #(
    parameter int WINDOW_MAX = 65536,
    parameter int ORDER_MAX  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bbg_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [bbg_pkg::DATA_W-1:0]   i_cfg_data,
    input  logic [14:0]                  i_bin_index,
    input  logic                         i_first_bin,
    input  bbg_pkg::t_cmd                i_cmd,
    output bbg_pkg::t_sts                o_sts,
    output logic [16:0]                  o_gain,
    output logic [14:0]                  o_pos_index,
    output logic [15:0]                  o_neg_index,
    output logic [47:0]                  o_bandwidth_sum
);

    localparam logic [20:0] WMAX = 21'(WINDOW_MAX);
    localparam logic [6:0]  OMAX = 7'(ORDER_MAX);

    // configuration
    logic [1:0]  r_type;
    logic [4:0]  r_order;
    logic [16:0] r_win;
    logic [23:0] r_hcut;
    logic [23:0] r_lcut;
    logic [31:0] r_bw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type  <= bbg_pkg::TYPE_LP;
            r_order <= 5'd4;
            r_win   <= 17'd1024;
            r_hcut  <= 24'd256;
            r_lcut  <= 24'd65536;
            r_bw    <= 32'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bbg_pkg::REG_TYPE:  r_type  <= i_cfg_data[1:0];
                bbg_pkg::REG_ORDER: r_order <= i_cfg_data[4:0];
                bbg_pkg::REG_WIN:   r_win   <= i_cfg_data[16:0];
                bbg_pkg::REG_HCUT:  r_hcut  <= i_cfg_data[23:0];
                bbg_pkg::REG_LCUT:  r_lcut  <= i_cfg_data[23:0];
                bbg_pkg::REG_BW:    r_bw    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped order and window
    logic [6:0]  ord_n;
    logic [16:0] nwin;

    always_comb begin
        ord_n = 7'(r_order);
        if (ord_n == 7'd0) begin
            ord_n = 7'd1;
        end
        if (ord_n > OMAX) begin
            ord_n = OMAX;
        end
    end

    assign nwin           = ({4'b0, r_win} > WMAX) ? WMAX[16:0] : r_win;
    assign o_sts.pow_last = 7'((ord_n - 7'd1) << 1);

    // ratio a/b in Q8 bin units, taken as the smaller magnitude over the larger
    logic signed [26:0] iq, hq, lq, a_s, b_s;
    logic [25:0]        ua, ub;

    assign iq = 27'(signed'({1'b0, i_bin_index, 8'b0}));
    assign hq = 27'(signed'({1'b0, r_hcut}));
    assign lq = 27'(signed'({1'b0, r_lcut}));

    always_comb begin
        case (r_type)
            bbg_pkg::TYPE_HP: begin
                a_s = hq;
                b_s = iq;
            end
            bbg_pkg::TYPE_LP: begin
                a_s = iq;
                b_s = lq;
            end
            bbg_pkg::TYPE_BP: begin
                a_s = (iq <<< 1) - lq - hq;
                b_s = lq - hq;
            end
            default: begin
                a_s = lq - hq;
                b_s = (iq <<< 1) - lq - hq;
            end
        endcase
    end

    assign ua = a_s[26] ? 26'(-a_s) : a_s[25:0];
    assign ub = b_s[26] ? 26'(-b_s) : b_s[25:0];

    logic [14:0] r_idx;
    logic        r_first;
    logic        r_zero;
    logic        r_inv;
    logic [25:0] r_num;
    logic [25:0] r_den;
    logic [15:0] r_neg;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx   <= i_bin_index;
            r_first <= i_first_bin;
            r_zero  <= (b_s == '0);
            r_inv   <= (ua > ub);
            r_num   <= (ua > ub) ? ub : ua;
            r_den   <= (ua > ub) ? ua : ub;
        end
    end

    // shared restoring divider, one quotient bit per cycle
    logic [31:0] r_rem;
    logic [30:0] r_low;
    logic [31:0] r_div;
    logic [32:0] div_t;
    logic        div_ge;

    // power loop
    logic [30:0] r_q;
    logic [30:0] r_p;
    logic [61:0] pow_prod;

    assign div_t    = {r_rem, r_low[30]};
    assign div_ge   = (div_t >= {1'b0, r_div});
    assign pow_prod = r_p * r_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= '0;
            r_low <= {i_bin_index, 16'b0};
            r_div <= 32'(nwin);
        end else if (i_cmd.divq_init) begin
            r_rem <= 32'(r_num[25:1]);
            r_low <= {r_num[0], 30'b0};
            r_div <= 32'(r_den);
        end else if (i_cmd.divs_init) begin
            r_div <= 32'h4000_0000 + 32'(r_p);
            if (r_inv) begin
                r_rem <= 32'(r_p[30:1]);
                r_low <= {r_p[0], 30'b0};
            end else begin
                r_rem <= 32'h2000_0000;
                r_low <= '0;
            end
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? 32'(div_t - {1'b0, r_div}) : div_t[31:0];
            r_low <= {r_low[29:0], div_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.neg_save) begin
            if (nwin == '0 || r_rem == '0) begin
                r_neg <= '0;
            end else begin
                r_neg <= 16'(nwin - r_rem[16:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pow_init) begin
            r_q <= r_low;
            r_p <= r_low;
        end else if (i_cmd.pow_step) begin
            r_p <= pow_prod[60:30];
        end
    end

    // square root of 4s, two radicand bits per cycle
    logic [33:0] r_sv;
    logic [19:0] r_srem;
    logic [16:0] r_root;
    logic [19:0] sq_t;
    logic [19:0] sq_trial;

    assign sq_t     = {r_srem[17:0], r_sv[33:32]};
    assign sq_trial = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_sv   <= {1'b0, r_low, 2'b00};
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sv <= {r_sv[31:0], 2'b00};
            if (sq_t >= sq_trial) begin
                r_srem <= sq_t - sq_trial;
                r_root <= {r_root[15:0], 1'b1};
            end else begin
                r_srem <= sq_t;
                r_root <= {r_root[15:0], 1'b0};
            end
        end
    end

    // bandwidth term and saturating sum
    logic [16:0] r_gain;
    logic [32:0] r_term;
    logic [47:0] r_acc;
    logic [16:0] gain_v;
    logic [48:0] bw_prod;
    logic [47:0] acc_base;
    logic [48:0] acc_sum;

    assign gain_v   = r_zero ? 17'd0 : r_root;
    assign bw_prod  = gain_v * r_bw;
    assign acc_base = r_first ? 48'd0 : r_acc;
    assign acc_sum  = {1'b0, acc_base} + 49'(r_term);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_gain <= gain_v;
            r_term <= bw_prod[48:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.acc) begin
            r_acc <= acc_sum[48] ? bbg_pkg::ACC_MAX : acc_sum[47:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_gain          <= r_gain;
            o_pos_index     <= r_idx;
            o_neg_index     <= r_neg;
            o_bandwidth_sum <= r_acc;
        end
    end

endmodule
